// ===== sv/pgmap_pkg.sv =====
// Shared constants and types of the four-level page table mapper.
package pgmap_pkg;

    localparam int POOL_PAGES_DEF    = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int LEVELS            = 4;

    localparam logic [31:0] PAGE_BYTES    = 32'h0000_1000;
    localparam logic [31:0] BASE_RESET    = 32'h0010_0000;
    localparam logic [31:0] BASE_MASK     = 32'hFFFF_F000;
    localparam logic [63:0] PRESENT_RW    = 64'd3;
    localparam logic        REG_POOL_BASE = 1'b0;

    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_USED  = 10'b00_0000_0100,
        S_PAGE  = 10'b00_0000_1000,
        S_RD    = 10'b00_0001_0000,
        S_FIT   = 10'b00_0010_0000,
        S_NEWPG = 10'b00_0100_0000,
        S_ALLOC = 10'b00_1000_0000,
        S_LEAF  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

endpackage

// ===== sv/four_level_page_table_mapper.sv =====
// Top level of the four-level page table mapper: sequencer, table memory and shared adder.
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         tvalid / tready         tdata: physical_address, virtual_address
//  m_axis    out        tvalid / tready         tdata: next_free_address; tuser: pool_full
//  APB       in         psel, penable, pwrite   pwdata: table_pool_base (paddr 0)
//
// After reset a clearing pass zeroes all POOL_PAGES * 512 table entries (8192 at
// the default size); no request is taken until it ends.
// A request is carried through to its result before the next one is taken: the
// entries are read one level at a time through the single read port, and every
// pointer step goes through the one 32-bit adder. A finished result waits in the
// output register while the next request is accepted; the block stalls only when
// a result is ready and the output register is still occupied and m_axis_tready is low.
module four_level_page_table_mapper #(
    parameter int POOL_PAGES = pgmap_pkg::POOL_PAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [51:0] physical_address, [99:52] virtual_address, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] next_free_address
    output logic [31:0]  m_axis_tdata,
    // [0] pool_full
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W  = pgmap_pkg::IDX_W;
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int CNT_W  = PAGE_W + 1;
    localparam int AW     = PAGE_W + IDX_W;
    localparam int DEPTH  = POOL_PAGES * pgmap_pkg::ENTRIES_PER_TABLE;

    // Control registers
    pgmap_pkg::t_state r_state, n_state;
    logic              r_root_valid, n_root_valid;
    logic              r_free_valid, n_free_valid;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_cfg_base, n_cfg_base;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;

    // Datapath registers
    logic [31:0]       r_root_ptr, n_root_ptr;
    logic [31:0]       r_free_ptr, n_free_ptr;
    logic [31:0]       r_base, n_base;
    logic [31:0]       r_ptr, n_ptr;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [1:0]        r_lvl, n_lvl;
    logic [2:0]        r_need, n_need;
    logic              r_full, n_full;
    logic [CNT_W-1:0]  r_used, n_used;
    logic              r_used_over, n_used_over;
    logic [51:0]       r_paddr, n_paddr;
    logic [IDX_W-1:0]  r_idx [pgmap_pkg::LEVELS];
    logic [IDX_W-1:0]  n_idx [pgmap_pkg::LEVELS];
    logic [31:0]       r_out_data, n_out_data;
    logic              r_out_full, n_out_full;

    // Table memory
    logic [63:0]       r_table_mem [DEPTH];
    logic [63:0]       r_rd_data;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [63:0]       w_mem_wdata;
    logic [AW-1:0]     w_mem_raddr;

    // Shared adder
    logic [31:0]       w_alu_a, w_alu_b, w_alu_y;
    logic              w_alu_sub;
    logic [19:0]       w_page32;
    logic              w_in_pool;
    logic [PAGE_W-1:0] w_page;
    logic [CNT_W-1:0]  w_room;
    logic              w_cfg_wr;
    logic              w_in_acc;
    logic              w_out_load;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == pgmap_pkg::REG_POOL_BASE) ? r_cfg_base : 32'd0;
    assign w_cfg_wr      = psel && penable && pwrite && pready
                           && (paddr[2] == pgmap_pkg::REG_POOL_BASE);
    assign s_axis_tready = (r_state == pgmap_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_full;
    assign w_out_load    = (r_state == pgmap_pkg::S_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        case (r_state)
            pgmap_pkg::S_FIT, pgmap_pkg::S_ALLOC: begin
                w_alu_a   = r_free_ptr;
                w_alu_b   = pgmap_pkg::PAGE_BYTES;
                w_alu_sub = 1'b0;
            end
            pgmap_pkg::S_USED: begin
                w_alu_a   = r_free_ptr;
                w_alu_b   = r_base;
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_a   = r_ptr;
                w_alu_b   = r_base;
                w_alu_sub = 1'b1;
            end
        endcase
    end

    assign w_alu_y   = w_alu_a + (w_alu_sub ? ~w_alu_b : w_alu_b) + {31'd0, w_alu_sub};
    assign w_page32  = w_alu_y[31:12];
    assign w_in_pool = (w_page32 < 20'(POOL_PAGES));
    assign w_page    = w_page32[PAGE_W-1:0];
    assign w_room    = CNT_W'(POOL_PAGES) - r_used;

    // Memory port selection
    assign w_mem_raddr = {w_page, r_idx[r_lvl]};
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = {r_page, r_idx[r_lvl]};
        w_mem_wdata = 64'(r_free_ptr) | pgmap_pkg::PRESENT_RW;
        case (r_state)
            pgmap_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = 64'd0;
            end
            pgmap_pkg::S_ALLOC: begin
                w_mem_we = 1'b1;
            end
            pgmap_pkg::S_LEAF: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = 64'(r_paddr) | pgmap_pkg::PRESENT_RW;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_table_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_table_mem[w_mem_raddr];
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_root_valid = r_root_valid;
        n_free_valid = r_free_valid;
        n_cfg_base   = w_cfg_wr ? pwdata : r_cfg_base;
        n_clr_addr   = r_clr_addr;
        n_root_ptr   = r_root_ptr;
        n_free_ptr   = r_free_ptr;
        n_base       = r_base;
        n_ptr        = r_ptr;
        n_page       = r_page;
        n_lvl        = r_lvl;
        n_need       = r_need;
        n_full       = r_full;
        n_used       = r_used;
        n_used_over  = r_used_over;
        n_paddr      = r_paddr;
        n_idx        = r_idx;
        n_out_data   = r_out_data;
        n_out_full   = r_out_full;
        n_out_valid  = r_out_valid && !m_axis_tready;

        case (r_state)
            pgmap_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = pgmap_pkg::S_IDLE;
                end
            end
            pgmap_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_paddr  = s_axis_tdata[51:0];
                    n_idx[0] = s_axis_tdata[99:91];
                    n_idx[1] = s_axis_tdata[90:82];
                    n_idx[2] = s_axis_tdata[81:73];
                    n_idx[3] = s_axis_tdata[72:64];
                    n_full   = 1'b0;
                    // The first request fixes the pool base until the next reset.
                    if (!r_free_valid) begin
                        n_base       = r_cfg_base & pgmap_pkg::BASE_MASK;
                        n_free_ptr   = r_cfg_base & pgmap_pkg::BASE_MASK;
                        n_free_valid = 1'b1;
                    end
                    n_state = pgmap_pkg::S_USED;
                end
            end
            pgmap_pkg::S_USED: begin
                n_used_over = (w_page32 > 20'(POOL_PAGES));
                n_used      = w_page32[CNT_W-1:0];
                n_lvl       = 2'd0;
                if (!r_root_valid) begin
                    n_need  = 3'd4;
                    n_state = pgmap_pkg::S_FIT;
                end else begin
                    n_ptr   = r_root_ptr;
                    n_state = pgmap_pkg::S_PAGE;
                end
            end
            pgmap_pkg::S_PAGE: begin
                n_page = w_page;
                if (!w_in_pool) begin
                    n_full  = 1'b1;
                    n_state = pgmap_pkg::S_DONE;
                end else if (r_lvl == pgmap_pkg::LVL_LEAF) begin
                    n_need  = 3'd0;
                    n_state = pgmap_pkg::S_FIT;
                end else begin
                    n_state = pgmap_pkg::S_RD;
                end
            end
            pgmap_pkg::S_RD: begin
                if (r_rd_data == 64'd0) begin
                    n_need  = 3'd3 - {1'b0, r_lvl};
                    n_state = pgmap_pkg::S_FIT;
                end else begin
                    n_ptr   = {r_rd_data[31:12], 12'd0};
                    n_lvl   = r_lvl + 2'd1;
                    n_state = pgmap_pkg::S_PAGE;
                end
            end
            pgmap_pkg::S_FIT: begin
                if (r_used_over || (CNT_W'(r_need) > w_room)) begin
                    n_full  = 1'b1;
                    n_state = pgmap_pkg::S_DONE;
                end else if (r_need == 3'd0) begin
                    n_state = pgmap_pkg::S_LEAF;
                end else if (!r_root_valid) begin
                    n_root_ptr   = r_free_ptr;
                    n_root_valid = 1'b1;
                    n_ptr        = r_free_ptr;
                    n_free_ptr   = w_alu_y;
                    n_lvl        = 2'd0;
                    n_state      = pgmap_pkg::S_NEWPG;
                end else begin
                    n_state = pgmap_pkg::S_ALLOC;
                end
            end
            pgmap_pkg::S_ALLOC: begin
                // The missing entry now points at a fresh page, whose entries are all zero.
                n_ptr      = r_free_ptr;
                n_free_ptr = w_alu_y;
                n_lvl      = r_lvl + 2'd1;
                n_state    = pgmap_pkg::S_NEWPG;
            end
            pgmap_pkg::S_NEWPG: begin
                n_page  = w_page;
                n_state = (r_lvl == pgmap_pkg::LVL_LEAF) ? pgmap_pkg::S_LEAF
                                                         : pgmap_pkg::S_ALLOC;
            end
            pgmap_pkg::S_LEAF: begin
                n_state = pgmap_pkg::S_DONE;
            end
            pgmap_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_out_data  = r_free_ptr;
                    n_out_full  = r_full;
                    n_out_valid = 1'b1;
                    n_state     = pgmap_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pgmap_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pgmap_pkg::S_CLEAR;
            r_root_valid <= 1'b0;
            r_free_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cfg_base   <= pgmap_pkg::BASE_RESET;
            r_clr_addr   <= '0;
        end else begin
            r_state      <= n_state;
            r_root_valid <= n_root_valid;
            r_free_valid <= n_free_valid;
            r_out_valid  <= n_out_valid;
            r_cfg_base   <= n_cfg_base;
            r_clr_addr   <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_ptr  <= n_root_ptr;
        r_free_ptr  <= n_free_ptr;
        r_base      <= n_base;
        r_ptr       <= n_ptr;
        r_page      <= n_page;
        r_lvl       <= n_lvl;
        r_need      <= n_need;
        r_full      <= n_full;
        r_used      <= n_used;
        r_used_over <= n_used_over;
        r_paddr     <= n_paddr;
        r_idx       <= n_idx;
        r_out_data  <= n_out_data;
        r_out_full  <= n_out_full;
    end

`ifndef SYNTHESIS
    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_valid |-> ((32'(r_free_ptr - r_base) >> 12) <= 32'(POOL_PAGES)))
        else $error("free pointer ran past the end of the pool");

    a_root_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root_valid |-> (r_free_valid && (r_root_ptr == r_base)))
        else $error("root table is not the first page of the pool");

    a_write_alloc_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && (r_state != pgmap_pkg::S_CLEAR)) |->
        (32'(w_mem_waddr[AW-1:IDX_W]) < (32'(r_free_ptr - r_base) >> 12)))
        else $error("table write into a page that is not allocated");

    a_full_keeps_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_full) |=> (r_free_ptr == $past(r_free_ptr)))
        else $error("free pointer moved on a pool full result");
`endif

endmodule
